// ===== rtl/caac_pkg.sv =====
// shared types, constants and sizes of the card access alarm controller
package caac_pkg;

   localparam int MAX_USERS  = 16;
   localparam int ID_BYTES   = 7;

   localparam int SLOT_W     = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int CNT_W      = $clog2(MAX_USERS + 1);
   localparam int ID_W       = 56;
   localparam int LEN_W      = 3;
   localparam int ADC_W      = 10;
   localparam int MS_W       = 16;
   localparam int LED_W      = 8;
   localparam int FADE_W     = 9;
   localparam int SLOT_OUT_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int LEN_CAP    = (ID_BYTES < 7) ? ID_BYTES : 7;

   localparam logic [ADC_W-1:0]  RST_ARM_THRESHOLD = 10'd500;
   localparam logic [MS_W-1:0]   RST_SIREN_HOLD    = 16'd4000;
   localparam logic [MS_W-1:0]   RST_BLINK_PERIOD  = 16'd200;
   localparam logic [MS_W-1:0]   RST_FADE_PERIOD   = 16'd100;
   localparam logic [LED_W-1:0]  RST_FADE_STEP     = 8'd50;
   localparam logic [MS_W-1:0]   MS_MAX            = 16'hFFFF;
   localparam logic [LED_W-1:0]  LED_FULL          = 8'd255;
   localparam logic [FADE_W-1:0] FADE_CAP          = 9'd511;
   localparam logic [FADE_W-1:0] FADE_TOP          = 9'd255;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_SCAN    = 3'd1,
      ACT_ARM     = 3'd2,
      ACT_TRIGGER = 3'd3,
      ACT_ADD     = 3'd4,
      ACT_DELETE  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_ARMED     = 2'd1,
      MODE_TRIGGERED = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_NONE      = 3'd0,
      STATUS_GRANTED   = 3'd1,
      STATUS_UNKNOWN   = 3'd2,
      STATUS_IGNORED   = 3'd3,
      STATUS_ADDED     = 3'd4,
      STATUS_FULL      = 3'd5,
      STATUS_DELETED   = 3'd6,
      STATUS_NOT_FOUND = 3'd7
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ARM_THRESHOLD = 3'd0,
      CSR_SIREN_HOLD    = 3'd1,
      CSR_BLINK_PERIOD  = 3'd2,
      CSR_FADE_PERIOD   = 3'd3,
      CSR_FADE_STEP     = 3'd4
   } csr_index_type;

endpackage

// ===== rtl/caac_ram.sv =====
// generic single-write, single-read ram with registered read data
module caac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/card_access_alarm_controller_top.sv =====
// card access alarm controller: alarm mode, siren, led and authorised card table
//
// Ticks, arm, trigger, unused actions and non-classic cards go from the accept
// cycle, which updates the state, to a result cycle that loads the output
// register. Scan, add and delete first walk the card table one slot per cycle
// through the read port of the ID memory, stopping at a hit or after the last
// slot. The result cycle waits while the output register still holds a beat
// that has not been taken.
module card_access_alarm_controller_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_action,
   input  logic [caac_pkg::ADC_W-1:0]         req_adc_sample,
   input  logic [caac_pkg::ID_W-1:0]          req_card_id,
   input  logic [caac_pkg::LEN_W-1:0]         req_card_id_len,
   input  logic                               req_card_is_classic,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_alarm_mode,
   output logic                               rsp_siren_on,
   output logic [caac_pkg::LED_W-1:0]         rsp_led_level,
   output logic [2:0]                         rsp_status,
   output logic [caac_pkg::SLOT_OUT_W-1:0]    rsp_user_slot,
   input  logic                               csr_we,
   input  logic [caac_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [caac_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import caac_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [ADC_W-1:0]      arm_threshold_ff, arm_threshold_in;
   logic [MS_W-1:0]       siren_hold_ff, siren_hold_in;
   logic [MS_W-1:0]       blink_period_ff, blink_period_in;
   logic [MS_W-1:0]       fade_period_ff, fade_period_in;
   logic [LED_W-1:0]      fade_step_ff, fade_step_in;

   mode_type              mode_ff, mode_in;
   logic                  siren_ff, siren_in;
   logic [MS_W-1:0]       siren_elapsed_ff, siren_elapsed_in;
   logic [MS_W-1:0]       led_elapsed_ff, led_elapsed_in;
   logic                  blink_phase_ff, blink_phase_in;
   logic [FADE_W-1:0]     fade_value_ff, fade_value_in;
   logic                  fade_rising_ff, fade_rising_in;
   logic [LED_W-1:0]      led_out_ff, led_out_in;
   logic [MAX_USERS-1:0]  entry_valid_ff, entry_valid_in;

   action_type            op_ff, op_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [ID_W-1:0]       mask_ff, mask_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   status_type            status_ff, status_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_mode_ff, rsp_mode_in;
   logic                  rsp_siren_ff, rsp_siren_in;
   logic [LED_W-1:0]      rsp_led_ff, rsp_led_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic [LEN_W-1:0]      len_eff;
   logic [ID_W-1:0]       req_mask;
   logic [MS_W-1:0]       siren_inc;
   logic [MS_W-1:0]       led_inc;
   logic [FADE_W:0]       fade_sum;
   logic [FADE_W-1:0]     fade_up;
   logic [FADE_W-1:0]     fade_down;
   logic [FADE_W-1:0]     fade_next;
   logic [FADE_W-1:0]     step_wide;
   logic                  issue;
   logic                  id_match;
   logic                  hit;
   logic                  ram_wr_en;
   logic [ID_W-1:0]       ram_rd_data;

   // effective length and byte mask of the scanned id
   always_comb begin
      len_eff = req_card_id_len;
      if (len_eff == '0) begin
         len_eff = LEN_W'(1);
      end
      if (len_eff > LEN_W'(LEN_CAP)) begin
         len_eff = LEN_W'(LEN_CAP);
      end
      for (int b = 0; b < 7; b++) begin
         req_mask[8*b +: 8] = (b < int'(len_eff)) ? 8'hFF : 8'h00;
      end
   end

   assign siren_inc = (siren_elapsed_ff == MS_MAX) ? MS_MAX : siren_elapsed_ff + MS_W'(1);
   assign led_inc   = (led_elapsed_ff == MS_MAX) ? MS_MAX : led_elapsed_ff + MS_W'(1);
   assign step_wide = {1'b0, fade_step_ff};
   assign fade_sum  = {1'b0, fade_value_ff} + {2'b00, fade_step_ff};
   assign fade_up   = (fade_sum > {1'b0, FADE_CAP}) ? FADE_CAP : fade_sum[FADE_W-1:0];
   assign fade_down = (fade_value_ff >= step_wide) ? fade_value_ff - step_wide : '0;
   assign fade_next = fade_rising_ff ? fade_up : fade_down;

   assign issue    = (cnt_ff < CNT_W'(MAX_USERS));
   assign id_match = (((ram_rd_data ^ id_ff) & mask_ff) == '0);
   assign hit      = pend_ff && ((op_ff == ACT_ADD) ? !entry_valid_ff[pend_slot_ff]
                                                    : (entry_valid_ff[pend_slot_ff] && id_match));
   assign ram_wr_en = (state_ff == ST_WALK) && hit && (op_ff == ACT_ADD);

   caac_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_USERS)
   ) u_id_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pend_slot_ff),
      .wr_data (id_ff),
      .rd_en   ((state_ff == ST_WALK) && issue),
      .rd_addr (cnt_ff[SLOT_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in         = state_ff;
      arm_threshold_in = arm_threshold_ff;
      siren_hold_in    = siren_hold_ff;
      blink_period_in  = blink_period_ff;
      fade_period_in   = fade_period_ff;
      fade_step_in     = fade_step_ff;
      mode_in          = mode_ff;
      siren_in         = siren_ff;
      siren_elapsed_in = siren_elapsed_ff;
      led_elapsed_in   = led_elapsed_ff;
      blink_phase_in   = blink_phase_ff;
      fade_value_in    = fade_value_ff;
      fade_rising_in   = fade_rising_ff;
      led_out_in       = led_out_ff;
      entry_valid_in   = entry_valid_ff;
      op_in            = op_ff;
      id_in            = id_ff;
      mask_in          = mask_ff;
      cnt_in           = cnt_ff;
      pend_in          = pend_ff;
      pend_slot_in     = pend_slot_ff;
      status_in        = status_ff;
      slot_in          = slot_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_mode_in      = rsp_mode_ff;
      rsp_siren_in     = rsp_siren_ff;
      rsp_led_in       = rsp_led_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_slot_in      = rsp_slot_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ARM_THRESHOLD: arm_threshold_in = csr_wdata[ADC_W-1:0];
            CSR_SIREN_HOLD:    siren_hold_in    = csr_wdata[MS_W-1:0];
            CSR_BLINK_PERIOD:  blink_period_in  = csr_wdata[MS_W-1:0];
            CSR_FADE_PERIOD:   fade_period_in   = csr_wdata[MS_W-1:0];
            CSR_FADE_STEP:     fade_step_in     = csr_wdata[LED_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in     = action_type'(req_action);
               id_in     = req_card_id & req_mask;
               mask_in   = req_mask;
               status_in = STATUS_NONE;
               slot_in   = '0;
               state_in  = ST_EMIT;
               unique case (action_type'(req_action))
                  ACT_TICK: begin
                     siren_elapsed_in = siren_inc;
                     led_elapsed_in   = led_inc;
                     unique case (mode_ff)
                        MODE_OFF: begin
                           led_out_in = '0;
                        end
                        MODE_TRIGGERED: begin
                           if (led_inc >= blink_period_ff) begin
                              blink_phase_in = !blink_phase_ff;
                              led_elapsed_in = '0;
                              led_out_in     = blink_phase_ff ? '0 : LED_FULL;
                           end
                        end
                        MODE_ARMED: begin
                           if (led_inc >= fade_period_ff) begin
                              led_elapsed_in = '0;
                              fade_value_in  = fade_next;
                              if ((fade_next > FADE_TOP) || (fade_next < step_wide)) begin
                                 fade_rising_in = !fade_rising_ff;
                              end
                              led_out_in = (fade_next > FADE_TOP) ? LED_FULL
                                                                  : fade_next[LED_W-1:0];
                           end
                        end
                        default: begin
                        end
                     endcase
                     if (req_adc_sample > arm_threshold_ff) begin
                        mode_in = MODE_ARMED;
                     end
                     if ((mode_in == MODE_TRIGGERED) && (siren_inc > siren_hold_ff)) begin
                        siren_in = 1'b0;
                     end
                  end
                  ACT_ARM: begin
                     mode_in = MODE_ARMED;
                  end
                  ACT_TRIGGER: begin
                     mode_in = MODE_TRIGGERED;
                  end
                  ACT_SCAN, ACT_ADD, ACT_DELETE: begin
                     if (!req_card_is_classic) begin
                        status_in = STATUS_IGNORED;
                     end else begin
                        state_in = ST_WALK;
                        cnt_in   = '0;
                        pend_in  = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            pend_in      = issue;
            pend_slot_in = cnt_ff[SLOT_W-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (hit) begin
               state_in = ST_EMIT;
               slot_in  = pend_slot_ff;
               unique case (op_ff)
                  ACT_SCAN: begin
                     mode_in   = MODE_OFF;
                     siren_in  = 1'b0;
                     status_in = STATUS_GRANTED;
                  end
                  ACT_ADD: begin
                     entry_valid_in[pend_slot_ff] = 1'b1;
                     status_in = STATUS_ADDED;
                  end
                  default: begin
                     entry_valid_in[pend_slot_ff] = 1'b0;
                     status_in = STATUS_DELETED;
                  end
               endcase
            end else if (!pend_ff && !issue) begin
               state_in = ST_EMIT;
               unique case (op_ff)
                  ACT_SCAN: begin
                     status_in = STATUS_UNKNOWN;
                     if (mode_ff == MODE_ARMED) begin
                        mode_in          = MODE_TRIGGERED;
                        siren_in         = 1'b1;
                        siren_elapsed_in = '0;
                     end
                  end
                  ACT_ADD: begin
                     status_in = STATUS_FULL;
                  end
                  default: begin
                     status_in = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_mode_in   = mode_ff;
               rsp_siren_in  = siren_ff;
               rsp_led_in    = led_out_ff;
               rsp_status_in = status_ff;
               rsp_slot_in   = SLOT_OUT_W'(slot_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         arm_threshold_ff <= RST_ARM_THRESHOLD;
         siren_hold_ff    <= RST_SIREN_HOLD;
         blink_period_ff  <= RST_BLINK_PERIOD;
         fade_period_ff   <= RST_FADE_PERIOD;
         fade_step_ff     <= RST_FADE_STEP;
         mode_ff          <= MODE_OFF;
         siren_ff         <= 1'b0;
         siren_elapsed_ff <= '0;
         led_elapsed_ff   <= '0;
         blink_phase_ff   <= 1'b0;
         fade_value_ff    <= '0;
         fade_rising_ff   <= 1'b1;
         led_out_ff       <= '0;
         entry_valid_ff   <= '0;
         cnt_ff           <= '0;
         pend_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         arm_threshold_ff <= arm_threshold_in;
         siren_hold_ff    <= siren_hold_in;
         blink_period_ff  <= blink_period_in;
         fade_period_ff   <= fade_period_in;
         fade_step_ff     <= fade_step_in;
         mode_ff          <= mode_in;
         siren_ff         <= siren_in;
         siren_elapsed_ff <= siren_elapsed_in;
         led_elapsed_ff   <= led_elapsed_in;
         blink_phase_ff   <= blink_phase_in;
         fade_value_ff    <= fade_value_in;
         fade_rising_ff   <= fade_rising_in;
         led_out_ff       <= led_out_in;
         entry_valid_ff   <= entry_valid_in;
         cnt_ff           <= cnt_in;
         pend_ff          <= pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      mask_ff       <= mask_in;
      pend_slot_ff  <= pend_slot_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      rsp_mode_ff   <= rsp_mode_in;
      rsp_siren_ff  <= rsp_siren_in;
      rsp_led_ff    <= rsp_led_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alarm_mode = rsp_mode_ff;
   assign rsp_siren_on   = rsp_siren_ff;
   assign rsp_led_level  = rsp_led_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_user_slot  = rsp_slot_ff;

endmodule

// ===== rtl/caac_checker.sv =====
// port-level checker of the card access alarm controller and its bind
module caac_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_alarm_mode,
   input logic                            rsp_siren_on,
   input logic [caac_pkg::LED_W-1:0]      rsp_led_level,
   input logic [2:0]                      rsp_status,
   input logic [caac_pkg::SLOT_OUT_W-1:0] rsp_user_slot
);

   import caac_pkg::*;

   // a stalled result beat holds its status, alarm mode, led level and slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_alarm_mode) && $stable(rsp_led_level) && $stable(rsp_user_slot))
      else $error("stalled result beat changed");

   // one item in flight at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in flight");

   // only the three alarm modes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_alarm_mode != 2'd3)
      else $error("invalid alarm mode");

   // a granted card leaves the alarm off and the siren quiet
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_GRANTED) |-> (rsp_alarm_mode == MODE_OFF)
         && !rsp_siren_on)
      else $error("granted card did not disarm");

   // no slot where no table entry applies
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STATUS_NONE) || (rsp_status == STATUS_IGNORED)
         || (rsp_status == STATUS_FULL) || (rsp_status == STATUS_NOT_FOUND)
         || (rsp_status == STATUS_UNKNOWN)) |-> rsp_user_slot == '0)
      else $error("slot reported without a table entry");

endmodule

bind card_access_alarm_controller_top caac_checker u_caac_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_alarm_mode (rsp_alarm_mode),
   .rsp_siren_on   (rsp_siren_on),
   .rsp_led_level  (rsp_led_level),
   .rsp_status     (rsp_status),
   .rsp_user_slot  (rsp_user_slot)
);

// ===== bench/tb_top.sv =====
// self-checking testbench for the card access alarm controller
`timescale 1ns / 100ps

module tb_top;
   import caac_pkg::*;

   localparam logic [2:0]  ACT_SPARE6     = 3'd6;
   localparam logic [2:0]  ACT_SPARE7     = 3'd7;
   localparam logic [55:0] ID_ALL_ONES    = {56{1'b1}};
   localparam logic [55:0] ID_SHORT       = {48'hFFFF_FFFF_FFFF, 8'h5A};
   localparam logic [55:0] ID_STRANGER    = 56'h12_3456_789A_BCDE;
   localparam int          ID_POOL_N      = 6;
   localparam int          LONG_HOLD      = 400;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          OFF_TICKS      = 20;
   localparam int          CYCLE_LIMIT    = 1_000_000;
   localparam int          MAX_REPORTS    = 40;

   typedef struct packed {
      logic [2:0]       action;
      logic [ADC_W-1:0] adc;
      logic [ID_W-1:0]  card_id;
      logic [LEN_W-1:0] len;
      logic             classic;
   } card_cmd_t;

   typedef struct packed {
      mode_type              mode;
      logic                  siren;
      logic [LED_W-1:0]      led;
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot;
   } alarm_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [2:0]            req_action = '0;
   logic [ADC_W-1:0]      req_adc_sample = '0;
   logic [ID_W-1:0]       req_card_id = '0;
   logic [LEN_W-1:0]      req_card_id_len = '0;
   logic                  req_card_is_classic = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_alarm_mode;
   logic                  rsp_siren_on;
   logic [LED_W-1:0]      rsp_led_level;
   logic [2:0]            rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_user_slot;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   card_access_alarm_controller_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_adc_sample      (req_adc_sample),
      .req_card_id         (req_card_id),
      .req_card_id_len     (req_card_id_len),
      .req_card_is_classic (req_card_is_classic),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_alarm_mode      (rsp_alarm_mode),
      .rsp_siren_on        (rsp_siren_on),
      .rsp_led_level       (rsp_led_level),
      .rsp_status          (rsp_status),
      .rsp_user_slot       (rsp_user_slot),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // alarm state as this bench sees it
   logic [ADC_W-1:0]  cfg_arm_threshold = RST_ARM_THRESHOLD;
   logic [MS_W-1:0]   cfg_siren_hold    = RST_SIREN_HOLD;
   logic [MS_W-1:0]   cfg_blink_period  = RST_BLINK_PERIOD;
   logic [MS_W-1:0]   cfg_fade_period   = RST_FADE_PERIOD;
   logic [LED_W-1:0]  cfg_fade_step     = RST_FADE_STEP;
   mode_type          model_mode        = MODE_OFF;
   logic              siren_level       = 1'b0;
   logic [MS_W-1:0]   siren_ms          = '0;
   logic [MS_W-1:0]   led_ms            = '0;
   logic              blink_on          = 1'b0;
   logic [FADE_W-1:0] fade_level        = '0;
   logic              fade_up           = 1'b1;
   logic [LED_W-1:0]  led_level         = '0;
   logic              card_valid [MAX_USERS];
   logic [ID_W-1:0]   card_ids   [MAX_USERS];

   card_cmd_t     cmd_backlog [$];
   alarm_result_t pending_results [$];
   logic [ID_W-1:0] id_pool [ID_POOL_N];

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  error_count    = 0;
   int  cycle_count    = 0;
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   int  long_hold_seq  = 0;
   int  hold_seen      = 0;
   int  hold_left      = 0;
   bit  sender_pause   = 1'b0;
   logic req_beat_taken = 1'b0;

   initial begin
      for (int k = 0; k < MAX_USERS; k++) begin
         card_valid[k] = 1'b0;
      end
   end

   initial forever #1 clock = ~clock;

   function automatic int find_card(logic [ID_W-1:0] id, logic [ID_W-1:0] id_mask);
      int hit;
      hit = -1;
      for (int i = MAX_USERS - 1; i >= 0; i--) begin
         if (card_valid[i] && ((card_ids[i] ^ id) & id_mask) == '0) hit = i;
      end
      return hit;
   endfunction

   function automatic alarm_result_t predict_alarm(card_cmd_t c);
      logic [LEN_W-1:0]  eff_len;
      logic [63:0]       wide_mask;
      logic [ID_W-1:0]   id_mask;
      logic [ID_W-1:0]   id;
      logic [FADE_W:0]   fade_sum;
      int                hit;
      alarm_result_t     r;
      eff_len = (c.len == 0) ? LEN_W'(1) : c.len;
      if (eff_len > LEN_CAP) eff_len = LEN_W'(LEN_CAP);
      wide_mask = (64'd1 << (8 * eff_len)) - 64'd1;
      id_mask = wide_mask[ID_W-1:0];
      id = c.card_id & id_mask;
      r.status = STATUS_NONE;
      r.slot = '0;
      case (c.action)
         ACT_TICK: begin
            if (siren_ms != MS_MAX) siren_ms = siren_ms + 1'b1;
            if (led_ms != MS_MAX) led_ms = led_ms + 1'b1;
            if (model_mode == MODE_OFF) begin
               led_level = '0;
            end else if (model_mode == MODE_TRIGGERED) begin
               if (led_ms >= cfg_blink_period) begin
                  blink_on = ~blink_on;
                  led_ms = '0;
                  led_level = blink_on ? LED_FULL : '0;
               end
            end else if (led_ms >= cfg_fade_period) begin
               led_ms = '0;
               if (fade_up) begin
                  fade_sum = {1'b0, fade_level} + cfg_fade_step;
                  fade_level = (fade_sum > FADE_CAP) ? FADE_CAP : fade_sum[FADE_W-1:0];
               end else begin
                  fade_level = (fade_level >= cfg_fade_step) ? fade_level - cfg_fade_step : '0;
               end
               if (fade_level > FADE_TOP || fade_level < cfg_fade_step) fade_up = ~fade_up;
               led_level = (fade_level > FADE_TOP) ? LED_FULL : fade_level[LED_W-1:0];
            end
            if (c.adc > cfg_arm_threshold) model_mode = MODE_ARMED;
            if (model_mode == MODE_TRIGGERED && siren_ms > cfg_siren_hold) siren_level = 1'b0;
         end
         ACT_ARM: model_mode = MODE_ARMED;
         ACT_TRIGGER: model_mode = MODE_TRIGGERED;
         ACT_SCAN, ACT_ADD, ACT_DELETE: begin
            if (!c.classic) begin
               r.status = STATUS_IGNORED;
            end else if (c.action == ACT_SCAN) begin
               hit = find_card(id, id_mask);
               if (hit >= 0) begin
                  model_mode = MODE_OFF;
                  siren_level = 1'b0;
                  r.status = STATUS_GRANTED;
                  r.slot = SLOT_OUT_W'(hit);
               end else begin
                  r.status = STATUS_UNKNOWN;
                  if (model_mode == MODE_ARMED) begin
                     model_mode = MODE_TRIGGERED;
                     siren_level = 1'b1;
                     siren_ms = '0;
                  end
               end
            end else if (c.action == ACT_ADD) begin
               hit = -1;
               for (int i = MAX_USERS - 1; i >= 0; i--) begin
                  if (!card_valid[i]) hit = i;
               end
               if (hit >= 0) begin
                  card_valid[hit] = 1'b1;
                  card_ids[hit] = id;
                  r.status = STATUS_ADDED;
                  r.slot = SLOT_OUT_W'(hit);
               end else begin
                  r.status = STATUS_FULL;
               end
            end else begin
               hit = find_card(id, id_mask);
               if (hit >= 0) begin
                  card_valid[hit] = 1'b0;
                  r.status = STATUS_DELETED;
                  r.slot = SLOT_OUT_W'(hit);
               end else begin
                  r.status = STATUS_NOT_FOUND;
               end
            end
         end
         default: ;
      endcase
      r.mode = model_mode;
      r.siren = siren_level;
      r.led = led_level;
      return r;
   endfunction

   function automatic card_cmd_t make_cmd(logic [2:0] act, logic [ADC_W-1:0] adc,
                                          logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                          logic classic);
      card_cmd_t c;
      c.action = act;
      c.adc = adc;
      c.card_id = id;
      c.len = len;
      c.classic = classic;
      return c;
   endfunction

   function automatic card_cmd_t rand_cmd(bit add_heavy);
      card_cmd_t   c;
      logic [63:0] raw;
      int          pick;
      int          lvl;
      pick = $urandom_range(99);
      if (add_heavy && pick < 70) pick = 75;
      if (pick < 45)      c.action = ACT_TICK;
      else if (pick < 60) c.action = ACT_SCAN;
      else if (pick < 65) c.action = ACT_ARM;
      else if (pick < 70) c.action = ACT_TRIGGER;
      else if (pick < 82) c.action = ACT_ADD;
      else if (pick < 96) c.action = ACT_DELETE;
      else if (pick < 98) c.action = ACT_SPARE6;
      else                c.action = ACT_SPARE7;
      lvl = $urandom_range(99);
      if (lvl < 10)      c.adc = ADC_W'($urandom_range(1023));
      else if (lvl < 15) c.adc = (cfg_arm_threshold == '1) ? '1 : cfg_arm_threshold + 1'b1;
      else               c.adc = ADC_W'($urandom_range(cfg_arm_threshold));
      raw = {$urandom, $urandom};
      c.card_id = ($urandom_range(99) < 75) ? id_pool[$urandom_range(ID_POOL_N - 1)]
                                             : raw[ID_W-1:0];
      c.len = ($urandom_range(99) < 60) ? LEN_W'(7) : LEN_W'($urandom_range(7));
      c.classic = ($urandom_range(99) < 90);
      return c;
   endfunction

   task automatic queue_cmd(card_cmd_t c);
      cmd_backlog.push_back(c);
      queued_count++;
   endtask

   task automatic wait_drained();
      while (accepted_count != queued_count || pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ARM_THRESHOLD: cfg_arm_threshold = val[ADC_W-1:0];
         CSR_SIREN_HOLD:    cfg_siren_hold = val;
         CSR_BLINK_PERIOD:  cfg_blink_period = val;
         CSR_FADE_PERIOD:   cfg_fade_period = val;
         CSR_FADE_STEP:     cfg_fade_step = val[LED_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_config(int thr, int hold, int blink, int fade, int step);
      wait_drained();
      write_csr(CSR_ARM_THRESHOLD, CSR_DATA_W'(thr));
      write_csr(CSR_SIREN_HOLD, CSR_DATA_W'(hold));
      write_csr(CSR_BLINK_PERIOD, CSR_DATA_W'(blink));
      write_csr(CSR_FADE_PERIOD, CSR_DATA_W'(fade));
      write_csr(CSR_FADE_STEP, CSR_DATA_W'(step));
   endtask

   task automatic run_phase(int n, int send_pct, int recv_pct, bit add_heavy);
      @(posedge clock);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (n) queue_cmd(rand_cmd(add_heavy));
      wait_drained();
   endtask

   function automatic void flag_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
   endfunction

   // sender: one beat held until taken
   always @(negedge clock) begin : drive_cmds
      card_cmd_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (cmd_backlog.size() != 0 && !sender_pause &&
             $urandom_range(99) >= send_idle_pct) begin
            nxt = cmd_backlog.pop_front();
            req_valid <= 1'b1;
            {req_action, req_adc_sample, req_card_id, req_card_id_len,
             req_card_is_classic} <= nxt;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin : take_results
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != long_hold_seq) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_seen <= long_hold_seq;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : observe
      card_cmd_t     seen_cmd;
      alarm_result_t want;
      if (reset) begin
         req_beat_taken <= 1'b0;
      end else begin
         req_beat_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("%0t: unexpected result beat, expected none actual mode %0d status %0d",
                           $time, rsp_alarm_mode, rsp_status);
            end else begin
               want = pending_results.pop_front();
               flag_field("alarm_mode", 64'(want.mode), 64'(rsp_alarm_mode));
               flag_field("siren_on", 64'(want.siren), 64'(rsp_siren_on));
               flag_field("led_level", 64'(want.led), 64'(rsp_led_level));
               flag_field("status", 64'(want.status), 64'(rsp_status));
               flag_field("user_slot", 64'(want.slot), 64'(rsp_user_slot));
            end
         end
         if (req_valid && req_ready) begin
            seen_cmd = {req_action, req_adc_sample, req_card_id, req_card_id_len,
                        req_card_is_classic};
            pending_results.push_back(predict_alarm(seen_cmd));
            accepted_count++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("card_access_alarm_controller_top verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [63:0] raw;
      for (int i = 0; i < ID_POOL_N; i++) begin
         raw = {$urandom, $urandom};
         id_pool[i] = raw[ID_W-1:0];
      end
      // pool entries that agree on their low bytes only
      id_pool[1][23:0] = id_pool[0][23:0];
      id_pool[2][7:0] = id_pool[0][7:0];

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // directed pass at reset settings
      @(posedge clock);
      queue_cmd(make_cmd(ACT_TICK, 10'd0, 56'd0, 3'd0, 1'b0));
      queue_cmd(make_cmd(ACT_TICK, 10'd1023, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SCAN, 10'd0, ID_ALL_ONES, 3'd7, 1'b0));
      queue_cmd(make_cmd(ACT_ADD, 10'd0, ID_ALL_ONES, 3'd7, 1'b0));
      queue_cmd(make_cmd(ACT_DELETE, 10'd0, ID_ALL_ONES, 3'd7, 1'b0));
      queue_cmd(make_cmd(ACT_ADD, 10'd0, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_ADD, 10'd0, ID_SHORT, 3'd0, 1'b1));
      queue_cmd(make_cmd(ACT_ADD, 10'd0, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SCAN, 10'd0, 56'd0, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_TICK, 10'd500, 56'd0, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_TRIGGER, 10'd0, 56'd0, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SPARE6, 10'd1023, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SPARE7, 10'd1023, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_ARM, 10'd0, 56'd0, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SCAN, 10'd0, {32'd0, 24'hFF_FFFF}, 3'd3, 1'b1));
      queue_cmd(make_cmd(ACT_SCAN, 10'd0, ID_STRANGER, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_DELETE, 10'd0, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SCAN, 10'd0, ID_ALL_ONES, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_DELETE, 10'd0, 56'h5A, 3'd1, 1'b1));
      queue_cmd(make_cmd(ACT_DELETE, 10'd0, ID_STRANGER, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_TICK, 10'd501, 56'd0, 3'd7, 1'b1));
      queue_cmd(make_cmd(ACT_SCAN, 10'd0, ID_ALL_ONES, 3'd7, 1'b1));
      wait_drained();

      // upper extremes, a run of ticks while off
      apply_config(1023, 65535, 65535, 65535, 1);
      @(posedge clock);
      repeat (OFF_TICKS)
         queue_cmd(make_cmd(ACT_TICK, ADC_W'($urandom_range(1023)), 56'd0, 3'd7, 1'b0));
      wait_drained();
      run_phase(40, 0, 0, 1'b0);

      // lower extremes
      apply_config(0, 0, 1, 1, 255);
      run_phase(60, 65, 0, 1'b0);

      apply_config(300, 6, 2, 1, 90);
      run_phase(80, 0, 65, 1'b0);

      // back-pressure: receiver holds off while the sender keeps offering
      apply_config(600, 20, 3, 2, 37);
      @(posedge clock);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold_seq++;
      repeat (80) queue_cmd(rand_cmd(1'b0));
      while (accepted_count < queued_count - 40) @(negedge clock);
      @(posedge clock);
      sender_pause = 1'b1;
      while (pending_results.size() != 0) @(negedge clock);
      @(posedge clock);
      sender_pause = 1'b0;
      wait_drained();

      // add-heavy phase that drives the table towards full
      apply_config(450, 12, 4, 3, 200);
      run_phase(40, 18, 18, 1'b1);

      apply_config($urandom_range(1023), $urandom_range(40), $urandom_range(6, 1),
                   $urandom_range(6, 1), $urandom_range(255, 1));
      run_phase(80, 18, 18, 1'b0);

      wait_drained();
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("card_access_alarm_controller_top verification clean");
      end else begin
         $display("card_access_alarm_controller_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/caac_pkg.sv
rtl/caac_ram.sv
rtl/card_access_alarm_controller_top.sv
rtl/caac_checker.sv
bench/tb_top.sv
